/* hw/rtl/lsra_pkg.sv */
// Shared types and constants for the linear scan register allocator.
// Used by the configuration block, the controller, the datapath and the top level.
`default_nettype none
package lsra_pkg;
	localparam int MAX_REGS = 16;
	localparam int REG_W    = 4;
	localparam int POS_W    = 16;
	localparam int ID_W     = 16;
	localparam int CNT_W    = 5;
	localparam int MAP_W    = 32;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		REG_INT_COUNT   = 3'd0,
		REG_FLT_COUNT   = 3'd1,
		REG_INT_TEMP    = 3'd2,
		REG_FLT_TEMP    = 3'd3,
		REG_INT_ARG_MAP = 3'd4,
		REG_FLT_ARG_MAP = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]    int_count;
		logic [CNT_W-1:0]    flt_count;
		logic [MAX_REGS-1:0] int_temp;
		logic [MAX_REGS-1:0] flt_temp;
		logic [MAP_W-1:0]    int_map;
		logic [MAP_W-1:0]    flt_map;
	} cfg_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [POS_W-1:0] stop;
		logic [REG_W-1:0] preg;
	} ent_t;

	typedef struct packed {
		logic load;
		logic expire;
		logic pick;
		logic update;
		logic out1;
	} cmd_t;

	typedef struct packed {
		logic exp_any;
		logic evict;
	} sts_t;
endpackage
`default_nettype wire

/* hw/rtl/lsra_cfg.sv */
// Configuration register file behind the APB-style port.
// Depends on lsra_pkg for the register indexes and the cfg_t bundle.
`default_nettype none
module lsra_cfg
	import lsra_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);
	cfg_t cfg_q;
	logic [2:0] idx;
	logic wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.int_count <= CNT_W'(MAX_REGS);
			cfg_q.flt_count <= CNT_W'(MAX_REGS);
			cfg_q.int_temp  <= '0;
			cfg_q.flt_temp  <= '0;
			cfg_q.int_map   <= '0;
			cfg_q.flt_map   <= '0;
		end else if (wr) begin
			case (idx)
				REG_INT_COUNT:   cfg_q.int_count <= pwdata[CNT_W-1:0];
				REG_FLT_COUNT:   cfg_q.flt_count <= pwdata[CNT_W-1:0];
				REG_INT_TEMP:    cfg_q.int_temp  <= pwdata[MAX_REGS-1:0];
				REG_FLT_TEMP:    cfg_q.flt_temp  <= pwdata[MAX_REGS-1:0];
				REG_INT_ARG_MAP: cfg_q.int_map   <= pwdata[MAP_W-1:0];
				REG_FLT_ARG_MAP: cfg_q.flt_map   <= pwdata[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_INT_COUNT:   prdata = DATA_W'(cfg_q.int_count);
			REG_FLT_COUNT:   prdata = DATA_W'(cfg_q.flt_count);
			REG_INT_TEMP:    prdata = DATA_W'(cfg_q.int_temp);
			REG_FLT_TEMP:    prdata = DATA_W'(cfg_q.flt_temp);
			REG_INT_ARG_MAP: prdata = cfg_q.int_map;
			REG_FLT_ARG_MAP: prdata = cfg_q.flt_map;
			default:         prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

/* hw/rtl/lsra_ctrl.sv */
// Sequencing state machine: expiry loop, register pick, list update, second result.
// Depends on lsra_pkg for the command and status bundles.
`default_nettype none
module lsra_ctrl
	import lsra_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  sts_t      sts,
	output cmd_t      cmd,
	output logic      busy
);
	typedef enum logic [2:0] {S_IDLE, S_EXP, S_PICK, S_UPD, S_OUT1} state_t;
	state_t state_q;
	logic busy_q;

	assign busy       = busy_q;
	assign cmd.load   = start && !busy_q;
	assign cmd.expire = (state_q == S_EXP);
	assign cmd.pick   = (state_q == S_PICK);
	assign cmd.update = (state_q == S_UPD);
	assign cmd.out1   = (state_q == S_OUT1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXP;
						busy_q  <= 1'b1;
					end
				end
				S_EXP: begin
					// Stay while either class still has an expired head entry.
					if (!sts.exp_any) state_q <= S_PICK;
				end
				S_PICK: state_q <= S_UPD;
				S_UPD: begin
					if (sts.evict) begin
						state_q <= S_OUT1;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_OUT1: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/lsra_dp.sv */
// Datapath: captured interval, per-class sorted active lists, busy and used masks,
// register pick and result registers. Depends on lsra_pkg.
`default_nettype none
module lsra_dp
	import lsra_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  cfg_t                     cfg,
	input  wire logic [ID_W-1:0]     interval_id,
	input  wire logic [POS_W-1:0]    interval_start,
	input  wire logic [POS_W-1:0]    interval_end,
	input  wire logic                is_float,
	input  wire logic                has_param,
	input  wire logic [2:0]          param_slot,
	input  wire logic [MAX_REGS-1:0] occupied_mask,
	input  wire logic                last_interval,
	output logic                     result_strobe,
	output logic [ID_W-1:0]          result_id,
	output logic [REG_W-1:0]         assigned_reg,
	output logic                     spilled,
	output logic [MAX_REGS-1:0]      class_used_mask,
	output logic                     last
);
	logic [ID_W-1:0]     id_q;
	logic [POS_W-1:0]    start_q, end_q;
	logic                flo_q, hp_q, lastiv_q;
	logic [2:0]          slot_q;
	logic [MAX_REGS-1:0] forbid_q;

	ent_t                lst_q [2][MAX_REGS];
	logic [CNT_W-1:0]    cnt_q [2];
	logic [MAX_REGS-1:0] busy_q [2];
	logic [MAX_REGS-1:0] ever_q [2];

	logic             found_q;
	logic [REG_W-1:0] reg_q;
	logic [ID_W-1:0]  vid_q;

	logic                o_strobe_q, o_spl_q, o_last_q;
	logic [ID_W-1:0]     o_id_q;
	logic [REG_W-1:0]    o_reg_q;
	logic [MAX_REGS-1:0] o_used_q;

	// Expiry: one head entry per class per cycle.
	logic exp_c [2];
	always_comb begin
		for (int c = 0; c < 2; c++)
			exp_c[c] = (cnt_q[c] != '0) && (lst_q[c][0].stop <= start_q);
	end
	assign sts.exp_any = exp_c[0] || exp_c[1];

	// Register pick.
	logic [CNT_W-1:0]    limit;
	logic [MAX_REGS-1:0] occ, temp;
	logic [MAP_W-1:0]    amap;
	logic [REG_W-1:0]    ip, sreg;
	logic                pfree, useall, sfound, pk_found;
	always_comb begin
		limit = flo_q ? cfg.flt_count : cfg.int_count;
		if (limit > CNT_W'(MAX_REGS)) limit = CNT_W'(MAX_REGS);
		occ    = busy_q[flo_q] | forbid_q;
		temp   = flo_q ? cfg.flt_temp : cfg.int_temp;
		amap   = flo_q ? cfg.flt_map : cfg.int_map;
		ip     = amap[{slot_q, 2'b00} +: REG_W];
		pfree  = hp_q && !occ[ip];
		useall = !hp_q;
		sfound = 1'b0;
		sreg   = '0;
		for (int j = 0; j < MAX_REGS; j++) begin
			if (!sfound && (CNT_W'(j) < limit) && (useall ? !occ[j] : temp[j])) begin
				sfound = 1'b1;
				sreg   = REG_W'(j);
			end
		end
		pk_found = (pfree || sfound) && (cnt_q[flo_q] < CNT_W'(MAX_REGS));
	end

	// Update: eviction test and sorted insertion point.
	logic [CNT_W-1:0]    n, nn, nm1;
	ent_t                vict, ent_new;
	logic                evict, do_ins, pdone;
	logic [CNT_W-1:0]    p;
	logic [MAX_REGS-1:0] busy_new, ever_new;
	always_comb begin
		n     = cnt_q[flo_q];
		nm1   = n - CNT_W'(1);
		vict  = lst_q[flo_q][nm1[REG_W-1:0]];
		evict = !found_q && (n != '0) && (vict.stop > end_q);
		do_ins = found_q || evict;
		nn    = found_q ? n : nm1;
		p     = '0;
		pdone = 1'b0;
		for (int i = 0; i < MAX_REGS; i++) begin
			if (!pdone && (CNT_W'(i) < nn) && (lst_q[flo_q][i].stop <= end_q))
				p = CNT_W'(i + 1);
			else
				pdone = 1'b1;
		end
		ent_new.id   = id_q;
		ent_new.stop = end_q;
		ent_new.preg = found_q ? reg_q : vict.preg;
		busy_new = busy_q[flo_q];
		if (found_q) busy_new[reg_q] = 1'b1;
		ever_new = ever_q[flo_q] | busy_new;
	end
	assign sts.evict = evict;

	// List contents carry no reset; the count says which entries are live.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q     <= interval_id;
			start_q  <= interval_start;
			end_q    <= interval_end;
			flo_q    <= is_float;
			hp_q     <= has_param;
			slot_q   <= param_slot;
			forbid_q <= occupied_mask;
			lastiv_q <= last_interval;
		end
		if (cmd.expire) begin
			for (int c = 0; c < 2; c++)
				if (exp_c[c])
					for (int i = 0; i < MAX_REGS - 1; i++)
						lst_q[c][i] <= lst_q[c][i + 1];
		end
		if (cmd.pick) begin
			found_q <= pk_found;
			reg_q   <= pfree ? ip : sreg;
		end
		if (cmd.update) begin
			vid_q <= vict.id;
			if (do_ins)
				for (int i = 0; i < MAX_REGS; i++) begin
					if (CNT_W'(i) == p)
						lst_q[flo_q][i] <= ent_new;
					else if (CNT_W'(i) > p && i > 0)
						lst_q[flo_q][i] <= lst_q[flo_q][(i > 0) ? i - 1 : 0];
				end
			o_id_q   <= id_q;
			o_reg_q  <= found_q ? reg_q : (evict ? vict.preg : '0);
			o_spl_q  <= !do_ins;
			o_used_q <= ever_new;
			o_last_q <= !evict;
		end
		if (cmd.out1) begin
			o_id_q   <= vid_q;
			o_reg_q  <= '0;
			o_spl_q  <= 1'b1;
			o_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				cnt_q[c]  <= '0;
				busy_q[c] <= '0;
				ever_q[c] <= '0;
			end
			o_strobe_q <= 1'b0;
		end else begin
			o_strobe_q <= cmd.update || cmd.out1;
			if (cmd.expire) begin
				for (int c = 0; c < 2; c++)
					if (exp_c[c]) begin
						cnt_q[c]  <= cnt_q[c] - CNT_W'(1);
						busy_q[c][lst_q[c][0].preg] <= 1'b0;
					end
			end
			if (cmd.update) begin
				if (lastiv_q) begin
					for (int c = 0; c < 2; c++) begin
						cnt_q[c]  <= '0;
						busy_q[c] <= '0;
						ever_q[c] <= '0;
					end
				end else begin
					if (found_q) cnt_q[flo_q] <= n + CNT_W'(1);
					busy_q[flo_q] <= busy_new;
					ever_q[flo_q] <= ever_new;
				end
			end
		end
	end

	assign result_strobe   = o_strobe_q;
	assign result_id       = o_id_q;
	assign assigned_reg    = o_reg_q;
	assign spilled         = o_spl_q;
	assign class_used_mask = o_used_q;
	assign last            = o_last_q;
endmodule
`default_nettype wire

/* hw/rtl/linear_scan_register_allocator_top.sv */
// Linear scan register allocator. An accepted interval goes through the expiry loop,
// which runs while either class still has an expired head entry, then the register pick
// and the list update, which registers its result strobe; an eviction adds the spilled
// interval's result in the following cycle. busy falls with the last result of an
// interval, so a new start may be given then. Results cannot be stalled. Reset empties
// all lists, clears the masks and returns the configuration to its defaults.
`default_nettype none
module linear_scan_register_allocator_top
	import lsra_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [ID_W-1:0]     interval_id,
	input  wire logic [POS_W-1:0]    interval_start,
	input  wire logic [POS_W-1:0]    interval_end,
	input  wire logic                is_float,
	input  wire logic                has_param,
	input  wire logic [2:0]          param_slot,
	input  wire logic [MAX_REGS-1:0] occupied_mask,
	input  wire logic                last_interval,
	output logic                     result_strobe,
	output logic [ID_W-1:0]          result_id,
	output logic [REG_W-1:0]         assigned_reg,
	output logic                     spilled,
	output logic [MAX_REGS-1:0]      class_used_mask,
	output logic                     last,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic      [DATA_W-1:0]   prdata,
	output logic                     pready
);
	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	lsra_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	lsra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
	);

	lsra_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg(cfg),
		.interval_id(interval_id), .interval_start(interval_start),
		.interval_end(interval_end), .is_float(is_float), .has_param(has_param),
		.param_slot(param_slot), .occupied_mask(occupied_mask),
		.last_interval(last_interval), .result_strobe(result_strobe),
		.result_id(result_id), .assigned_reg(assigned_reg), .spilled(spilled),
		.class_used_mask(class_used_mask), .last(last)
	);
endmodule
`default_nettype wire

/* hw/rtl/lsra_chk.sv */
// Port-level checker for the allocator top level, attached by bind.
// Depends on lsra_pkg for field widths.
`default_nettype none
module lsra_chk
	import lsra_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             result_strobe,
	input wire logic [REG_W-1:0] assigned_reg,
	input wire logic             spilled,
	input wire logic             last
);
	// An accepted transfer makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after accept");
	// No result appears in the cycle right after an accept.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_strobe) else $error("result too early");
	// A first result that is not last is followed by the spilled one.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> result_strobe && spilled && last)
		else $error("second result missing");
	// A spilled result carries register zero.
	a_spill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && spilled |-> assigned_reg == '0) else $error("spill reg nonzero");
endmodule

bind linear_scan_register_allocator_top lsra_chk u_lsra_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_strobe(result_strobe), .assigned_reg(assigned_reg),
	.spilled(spilled), .last(last)
);
`default_nettype wire

/* tb/sv/linear_scan_register_allocator_top_test.sv */
// Self-checking testbench for the linear scan register allocator top level.
// Depends on lsra_pkg and linear_scan_register_allocator_top; predicts every
// assignment, spill and eviction and compares each result strobe against it.
`default_nettype none
module linear_scan_register_allocator_top_test;
	import lsra_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1400;

	typedef struct {
		logic [ID_W-1:0]     id;
		logic [POS_W-1:0]    first;
		logic [POS_W-1:0]    stop;
		logic                flt;
		logic                param;
		logic [2:0]          slot;
		logic [MAX_REGS-1:0] forbid;
		logic                final_iv;
	} interval_t;

	typedef struct {
		logic [ID_W-1:0]     id;
		logic [REG_W-1:0]    preg;
		logic                spill;
		logic [MAX_REGS-1:0] used;
		logic                last;
	} alloc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [ID_W-1:0] interval_id = '0;
	logic [POS_W-1:0] interval_start = '0;
	logic [POS_W-1:0] interval_end = '0;
	logic is_float = 1'b0;
	logic has_param = 1'b0;
	logic [2:0] param_slot = '0;
	logic [MAX_REGS-1:0] occupied_mask = '0;
	logic last_interval = 1'b0;
	logic result_strobe;
	logic [ID_W-1:0] result_id;
	logic [REG_W-1:0] assigned_reg;
	logic spilled;
	logic [MAX_REGS-1:0] class_used_mask;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	linear_scan_register_allocator_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.interval_id(interval_id), .interval_start(interval_start),
		.interval_end(interval_end), .is_float(is_float), .has_param(has_param),
		.param_slot(param_slot), .occupied_mask(occupied_mask),
		.last_interval(last_interval), .result_strobe(result_strobe),
		.result_id(result_id), .assigned_reg(assigned_reg), .spilled(spilled),
		.class_used_mask(class_used_mask), .last(last), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predicted allocator state, index 0 integer class, 1 float class.
	ent_t                live [2][MAX_REGS];
	int                  live_n [2];
	logic [MAX_REGS-1:0] busy_regs [2];
	logic [MAX_REGS-1:0] ever_regs [2];
	logic [CNT_W-1:0]    reg_count [2];
	logic [MAX_REGS-1:0] temp_regs [2];
	logic [MAP_W-1:0]    arg_map [2];

	alloc_t expected_allocs [$];
	int mismatches = 0;
	int quiet_cycles = 0;
	logic busy_seen = 1'b1;
	logic no_idle = 1'b0;

	task automatic clear_allocations();
		for (int c = 0; c < 2; c++) begin
			live_n[c] = 0;
			busy_regs[c] = '0;
			ever_regs[c] = '0;
		end
	endtask

	task automatic insert_live(int c, ent_t e);
		int j;
		j = 0;
		if (live_n[c] >= MAX_REGS)
			return;
		while (j < live_n[c] && !(e.stop < live[c][j].stop))
			j++;
		for (int k = live_n[c]; k > j; k--)
			live[c][k] = live[c][k-1];
		live[c][j] = e;
		live_n[c]++;
	endtask

	task automatic allocate_interval(interval_t iv);
		int c, j, limit, nres;
		logic found, useall;
		logic [REG_W-1:0] preg, ip;
		logic [MAX_REGS-1:0] occ;
		ent_t victim;
		alloc_t r [2];
		for (int k = 0; k < 2; k++) begin
			j = 0;
			while (j < live_n[k] && live[k][j].stop <= iv.first) begin
				busy_regs[k][live[k][j].preg] = 1'b0;
				j++;
			end
			for (int m = 0; m < live_n[k] - j; m++)
				live[k][m] = live[k][m+j];
			live_n[k] -= j;
		end
		c = iv.flt ? 1 : 0;
		limit = reg_count[c] > MAX_REGS ? MAX_REGS : reg_count[c];
		occ = busy_regs[c] | iv.forbid;
		found = 1'b0;
		useall = 1'b1;
		preg = '0;
		if (iv.param) begin
			ip = arg_map[c][4*iv.slot +: 4];
			if (!occ[ip]) begin
				preg = ip;
				found = 1'b1;
			end else
				useall = 1'b0;
		end
		if (!found) begin
			for (j = 0; j < limit; j++) begin
				if (useall ? !occ[j] : temp_regs[c][j]) begin
					preg = j[REG_W-1:0];
					found = 1'b1;
					break;
				end
			end
		end
		if (found && live_n[c] >= MAX_REGS)
			found = 1'b0;
		r[0] = '{id: iv.id, preg: preg, spill: 1'b0, used: '0, last: 1'b0};
		if (found) begin
			busy_regs[c][preg] = 1'b1;
			insert_live(c, '{id: iv.id, stop: iv.stop, preg: preg});
			nres = 1;
		end else if (live_n[c] > 0 && live[c][live_n[c]-1].stop > iv.stop) begin
			// The furthest-ending interval gives up its register to the new one.
			victim = live[c][live_n[c]-1];
			live_n[c]--;
			insert_live(c, '{id: iv.id, stop: iv.stop, preg: victim.preg});
			r[0].preg = victim.preg;
			r[1] = '{id: victim.id, preg: '0, spill: 1'b1, used: '0, last: 1'b0};
			nres = 2;
		end else begin
			r[0].spill = 1'b1;
			nres = 1;
		end
		ever_regs[c] |= busy_regs[c];
		for (int k = 0; k < nres; k++) begin
			r[k].used = ever_regs[c];
			r[k].last = (k == nres - 1);
			expected_allocs.push_back(r[k]);
		end
		if (iv.final_iv)
			clear_allocations();
	endtask

	always @(negedge clk)
		busy_seen <= busy;

	always @(negedge clk) begin
		alloc_t exp_r;
		if (arst_n && result_strobe) begin
			quiet_cycles = 0;
			if (expected_allocs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result id=%h reg=%0d spill=%b", result_id,
						assigned_reg, spilled);
			end else begin
				exp_r = expected_allocs.pop_front();
				if (result_id !== exp_r.id || assigned_reg !== exp_r.preg ||
						spilled !== exp_r.spill || class_used_mask !== exp_r.used ||
						last !== exp_r.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h/%0d/%b/%h/%b got %h/%0d/%b/%h/%b",
							exp_r.id, exp_r.preg, exp_r.spill, exp_r.used, exp_r.last,
							result_id, assigned_reg, spilled, class_used_mask, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Drives one interval and holds start until the transfer happens.
	task automatic send_interval(interval_t iv);
		interval_id <= iv.id;
		interval_start <= iv.first;
		interval_end <= iv.stop;
		is_float <= iv.flt;
		has_param <= iv.param;
		param_slot <= iv.slot;
		occupied_mask <= iv.forbid;
		last_interval <= iv.final_iv;
		start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy_seen)
				break;
		end
		allocate_interval(iv);
		quiet_cycles = 0;
		if (!no_idle && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (expected_allocs.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_INT_COUNT: reg_count[0] = value[CNT_W-1:0];
			REG_FLT_COUNT: reg_count[1] = value[CNT_W-1:0];
			REG_INT_TEMP: temp_regs[0] = value[MAX_REGS-1:0];
			REG_FLT_TEMP: temp_regs[1] = value[MAX_REGS-1:0];
			REG_INT_ARG_MAP: arg_map[0] = value;
			REG_FLT_ARG_MAP: arg_map[1] = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(logic [4:0] ic, logic [4:0] fc, logic [15:0] it,
			logic [15:0] ft, logic [31:0] im, logic [31:0] fm);
		write_reg(REG_INT_COUNT, DATA_W'(ic));
		write_reg(REG_FLT_COUNT, DATA_W'(fc));
		write_reg(REG_INT_TEMP, DATA_W'(it));
		write_reg(REG_FLT_TEMP, DATA_W'(ft));
		write_reg(REG_INT_ARG_MAP, im);
		write_reg(REG_FLT_ARG_MAP, fm);
	endtask

	function automatic interval_t mk(logic [15:0] id, logic [15:0] s, logic [15:0] e,
			logic f, logic p, logic [2:0] sl, logic [15:0] fb, logic fin);
		return '{id: id, first: s, stop: e, flt: f, param: p, slot: sl, forbid: fb,
			final_iv: fin};
	endfunction

	task automatic test_defaults_and_eviction();
		send_interval(mk(16'hFFFF, 0, 16'hFFFF, 0, 0, 0, 0, 0));
		// All registers forbidden, so the long-lived interval is evicted.
		send_interval(mk(16'h0001, 1, 10, 0, 0, 0, 16'hFFFF, 0));
		send_interval(mk(16'h0002, 2, 16'hFFFF, 0, 0, 0, 16'hFFFF, 0));
		send_interval(mk(16'h0003, 3, 20, 1, 0, 0, 16'h0001, 0));
		send_interval(mk(16'h0004, 10, 30, 1, 0, 0, 0, 1));
		wait_idle();
	endtask

	task automatic test_arg_slots();
		write_all(5'd16, 5'd16, 16'h8000, 16'h0000, 32'h7654_3210, 32'hFEDC_BA98);
		for (int s = 0; s < 8; s++)
			send_interval(mk(16'h0100 + 16'(s), 16'(s), 16'hFF00, s[0], 1, s[2:0], 0, 0));
		// Slot register already taken: int falls back to the temp mask, float spills.
		send_interval(mk(16'h0200, 8, 16'hFF10, 0, 1, 0, 0, 0));
		send_interval(mk(16'h0201, 9, 16'hFFF0, 1, 1, 1, 0, 1));
		wait_idle();
	endtask

	task automatic test_full_list();
		write_all(5'd31, 5'd0, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		for (int i = 0; i < 16; i++)
			send_interval(mk(16'h0300 + 16'(i), 16'(i), 16'h8000 + 16'(i), 0, 0, 0, 0, 0));
		// The temp rule finds a register but the active list is already full.
		send_interval(mk(16'h0310, 20, 16'h9000, 0, 1, 0, 0, 0));
		send_interval(mk(16'h0311, 21, 16'h0100, 1, 0, 0, 0, 0));
		send_interval(mk(16'h0312, 22, 16'h0200, 1, 1, 7, 16'hFFFF, 1));
		wait_idle();
	endtask

	function automatic logic [15:0] random_forbid();
		case ($urandom_range(0, 9))
			0: return 16'hFFFF;
			1, 2, 3: return 16'h0000;
			default: return 16'($urandom) & 16'($urandom) & 16'($urandom);
		endcase
	endfunction

	task automatic random_config();
		write_all(5'($urandom_range(0, 31)), 5'($urandom_range(1, 16)), 16'($urandom),
			($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom), $urandom, $urandom);
	endtask

	task automatic test_random();
		int sent, len, pos;
		interval_t iv;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 200 < 30 && sent >= 200) begin
				wait_idle();
				random_config();
			end
			no_idle = (sent >= 500 && sent < 800);
			len = $urandom_range(1, 40);
			pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63000)
				: $urandom_range(0, 50);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					iv = mk(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
						1'($urandom), 3'($urandom), random_forbid(), ($urandom_range(0, 15) == 0));
				end else begin
					pos += $urandom_range(0, 3);
					iv = mk(16'($urandom), 16'(pos), 16'(pos + $urandom_range(1, 60)),
						1'($urandom), ($urandom_range(0, 9) < 3), 3'($urandom),
						random_forbid(), (i == len - 1));
				end
				send_interval(iv);
				sent++;
			end
		end
		no_idle = 1'b0;
		wait_idle();
	endtask

	initial begin
		reg_count = '{5'd16, 5'd16};
		temp_regs = '{16'h0, 16'h0};
		arg_map = '{32'h0, 32'h0};
		clear_allocations();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_defaults_and_eviction();
		test_arg_slots();
		test_full_list();
		test_random();
		if (mismatches == 0 && expected_allocs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
